// ===== src/telnet_cp_pkg.sv =====
// Shared constants and types for the telnet command parser.
package telnet_cp_pkg;

    // Default subnegotiation buffer depth
    localparam int SUB_DEPTH_DEF = 16;

    // Telnet byte codes
    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_SE   = 8'd240;

    // Window size option and its report length
    localparam logic [7:0] OPT_NAWS = 8'd31;
    localparam int         NAWS_LEN = 5;

    // Event kinds
    localparam logic [1:0] EV_DATA = 2'd0;
    localparam logic [1:0] EV_OPT  = 2'd1;
    localparam logic [1:0] EV_SE   = 2'd2;

    // Output field widths
    localparam int LEN_W  = 5;
    localparam int DIM_W  = 16;
    localparam int DATA_W = 64;

    // One result transaction
    typedef struct packed {
        logic [1:0]       event_kind;
        logic [7:0]       data_byte;
        logic [7:0]       cmd_code;
        logic [7:0]       opt_code;
        logic [LEN_W-1:0] sub_length;
        logic             size_updated;
        logic [DIM_W-1:0] win_width;
        logic [DIM_W-1:0] win_height;
    } tcp_result_t;

endpackage

// ===== src/telnet_command_parser.sv =====
// Top level of the telnet command parser with window size capture.
//
// Usage:
//   s_ stream carries one received telnet byte per transaction (tdata[7:0]).
//   m_ stream carries zero or one event per received byte: tuser holds the
//   event kind (data byte, option command, subnegotiation end) and tdata the
//   event fields plus the current stored window width and height.
// Throughput: one byte per cycle while the output register has room. The parse
//   mode, command and buffer count are updated in the same cycle a byte is taken;
//   the result goes into a two-entry output register, so s_tready depends only on
//   that register's fill and not combinationally on m_tready.
// Reset: aresetn (synchronous, active low) returns to normal mode, clears the
//   pending command, buffer count and stored window size, and empties the
//   output register.
// Stall: while m_tready is low, results hold in the output register; once
//   both entries are full, s_tready drops until an entry drains.
module telnet_command_parser #(
    parameter int SUB_DEPTH = telnet_cp_pkg::SUB_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // data_byte, cmd_code, opt_code, sub_length,
                                   // size_updated, win_width, win_height, zero pad
    output logic [1:0]  m_tuser    // event_kind
);
    import telnet_cp_pkg::*;

    logic        in_fire;
    logic        res_valid;
    tcp_result_t res;
    tcp_result_t out_res;

    assign in_fire = s_tvalid && s_tready;

    telnet_cp_parse #(
        .SUB_DEPTH (SUB_DEPTH)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    telnet_cp_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire && res_valid),
        .push_data (res),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // Pack result fields, lowest first
    assign m_tuser = out_res.event_kind;
    assign m_tdata = {2'b00, out_res.win_height, out_res.win_width,
                      out_res.size_updated, out_res.sub_length,
                      out_res.opt_code, out_res.cmd_code, out_res.data_byte};

endmodule

// ===== src/telnet_cp_parse.sv =====
// Telnet parse state, subnegotiation capture and result formation.
module telnet_cp_parse #(
    parameter int SUB_DEPTH = telnet_cp_pkg::SUB_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_fire,
    input  logic [7:0]                 in_byte,
    output logic                       res_valid,
    output telnet_cp_pkg::tcp_result_t res
);
    import telnet_cp_pkg::*;

    localparam int CNT_W = $clog2(SUB_DEPTH + 1);

    // Parser modes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_IAC    = 2'd1;
    localparam logic [1:0] MODE_CMD    = 2'd2;
    localparam logic [1:0] MODE_SUB    = 2'd3;

    logic [1:0]       mode_reg, mode_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    // Only the first NAWS_LEN buffered bytes are ever inspected
    logic [7:0]       naws_reg [NAWS_LEN];
    logic             buf_wr;
    logic             is_cmd;
    logic             naws_hit;
    logic [LEN_W-1:0] len_sat;

    assign is_cmd = (in_byte == B_DO) || (in_byte == B_WILL) ||
                    (in_byte == B_DONT) || (in_byte == B_WONT);
    assign naws_hit = (32'(cnt_reg) == 32'(NAWS_LEN)) && (naws_reg[0] == OPT_NAWS);
    assign len_sat = (32'(cnt_reg) > 32'd31) ? 5'd31 : LEN_W'(cnt_reg);

    // Mode transitions and result selection
    always_comb begin
        mode_next   = mode_reg;
        cmd_next    = cmd_reg;
        cnt_next    = cnt_reg;
        width_next  = width_reg;
        height_next = height_reg;
        buf_wr      = 1'b0;
        res_valid   = 1'b0;
        res         = '0;
        unique case (mode_reg)
            MODE_NORMAL: begin
                if (in_byte == B_IAC) begin
                    mode_next = MODE_IAC;
                    cmd_next  = 8'd0;
                end else begin
                    res_valid     = 1'b1;
                    res.event_kind = EV_DATA;
                    res.data_byte  = in_byte;
                end
            end
            MODE_IAC: begin
                priority if (in_byte == B_SB) begin
                    mode_next = MODE_SUB;
                    cnt_next  = '0;
                end else if (in_byte == B_SE) begin
                    mode_next = MODE_NORMAL;
                    if (naws_hit) begin
                        width_next  = {naws_reg[1], naws_reg[2]};
                        height_next = {naws_reg[3], naws_reg[4]};
                    end
                    res_valid        = 1'b1;
                    res.event_kind   = EV_SE;
                    res.sub_length   = len_sat;
                    res.size_updated = naws_hit;
                end else if (is_cmd) begin
                    mode_next = MODE_CMD;
                    cmd_next  = in_byte;
                end else begin
                    mode_next      = MODE_NORMAL;
                    res_valid      = 1'b1;
                    res.event_kind = EV_OPT;
                    res.cmd_code   = cmd_reg;
                    res.opt_code   = in_byte;
                end
            end
            MODE_CMD: begin
                mode_next      = MODE_NORMAL;
                res_valid      = 1'b1;
                res.event_kind = EV_OPT;
                res.cmd_code   = cmd_reg;
                res.opt_code   = in_byte;
            end
            MODE_SUB: begin
                if (in_byte == B_IAC) begin
                    mode_next = MODE_IAC;
                    cmd_next  = 8'd0;
                end else if (cnt_reg < CNT_W'(SUB_DEPTH)) begin
                    buf_wr   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: ;
        endcase
        // Window size reflects this transaction's update
        res.win_width  = width_next;
        res.win_height = height_next;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_NORMAL;
            cmd_reg    <= 8'd0;
            cnt_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
        end else if (in_fire) begin
            mode_reg   <= mode_next;
            cmd_reg    <= cmd_next;
            cnt_reg    <= cnt_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Capture of the leading subnegotiation bytes
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NAWS_LEN; i++) begin
            if (in_fire && buf_wr && (32'(cnt_reg) == i)) begin
                naws_reg[i] <= in_byte;
            end
        end
    end

endmodule

// ===== src/telnet_cp_outbuf.sv =====
// Two-entry result register with skid slot for the master stream.
module telnet_cp_outbuf (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  telnet_cp_pkg::tcp_result_t push_data,
    output logic                       room,
    output logic                       out_valid,
    input  logic                       out_ready,
    output telnet_cp_pkg::tcp_result_t out_data
);
    import telnet_cp_pkg::*;

    logic [1:0]  cnt_reg, cnt_next;
    tcp_result_t ent0_reg, ent0_next;
    tcp_result_t ent1_reg, ent1_next;
    logic        pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = ent0_reg;
    assign room      = (cnt_reg != 2'd2);
    assign pop       = out_valid && out_ready;

    // Slot update: head is always ent0
    always_comb begin
        cnt_next  = cnt_reg;
        ent0_next = ent0_reg;
        ent1_next = ent1_reg;
        unique case ({push, pop})
            2'b11: begin
                if (cnt_reg == 2'd1) begin
                    ent0_next = push_data;
                end else begin
                    ent0_next = ent1_reg;
                    ent1_next = push_data;
                end
            end
            2'b01: begin
                ent0_next = ent1_reg;
                cnt_next  = cnt_reg - 2'd1;
            end
            2'b10: begin
                if (cnt_reg == 2'd0) begin
                    ent0_next = push_data;
                end else begin
                    ent1_next = push_data;
                end
                cnt_next = cnt_reg + 2'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the telnet command parser: byte stream in, events out.
module tb;
    import telnet_cp_pkg::*;

    localparam int SUB_DEPTH   = SUB_DEPTH_DEF;
    localparam int RAND_BYTES  = 400;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [1:0] {PM_NORMAL, PM_IAC, PM_CMD, PM_SUB} parse_mode_e;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;          // data_byte, cmd_code, opt_code, sub_length,
                                   // size_updated, win_width, win_height, zero pad
    logic [1:0]  m_tuser;          // event_kind

    // Byte stream waiting to be sent and events waiting to be seen
    logic [7:0]  rx_stream[$];
    tcp_result_t expected_events[$];

    // Predictor state
    parse_mode_e pmode    = PM_NORMAL;
    logic [7:0]  pend_cmd = '0;
    logic [7:0]  sub_buf[SUB_DEPTH];
    int          sub_cnt  = 0;
    logic [15:0] win_w    = '0;
    logic [15:0] win_h    = '0;

    int errors     = 0;
    int bytes_sent = 0;
    int n_data     = 0;
    int n_opt      = 0;
    int n_se       = 0;
    int n_size     = 0;
    int cycle_cnt  = 0;
    int burst_left = 0;
    int gap_left   = 0;
    int stall_tick = 0;

    telnet_command_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic logic is_cmd(input logic [7:0] b);
        return (b == B_DO || b == B_WILL || b == B_DONT || b == B_WONT);
    endfunction

    // Advance the parser state by one received byte; queue any event it causes
    task automatic parse_rx_byte(input logic [7:0] b);
        tcp_result_t ev;
        logic        has_event;
        ev        = '0;
        has_event = 1'b0;
        case (pmode)
            PM_NORMAL: begin
                if (b == B_IAC) begin
                    pmode    = PM_IAC;
                    pend_cmd = '0;
                end else begin
                    ev.event_kind = EV_DATA;
                    ev.data_byte  = b;
                    has_event     = 1'b1;
                end
            end
            PM_IAC: begin
                if (b == B_SB) begin
                    pmode   = PM_SUB;
                    sub_cnt = 0;
                end else if (b == B_SE) begin
                    pmode = PM_NORMAL;
                    // window size report: option byte plus four size bytes
                    if (sub_cnt == NAWS_LEN && sub_buf[0] == OPT_NAWS) begin
                        win_w           = {sub_buf[1], sub_buf[2]};
                        win_h           = {sub_buf[3], sub_buf[4]};
                        ev.size_updated = 1'b1;
                    end
                    ev.event_kind = EV_SE;
                    ev.sub_length = (sub_cnt > 31) ? 5'd31 : LEN_W'(sub_cnt);
                    has_event     = 1'b1;
                end else if (is_cmd(b)) begin
                    pmode    = PM_CMD;
                    pend_cmd = b;
                end else begin
                    pmode         = PM_NORMAL;
                    ev.event_kind = EV_OPT;
                    ev.cmd_code   = pend_cmd;
                    ev.opt_code   = b;
                    has_event     = 1'b1;
                end
            end
            PM_CMD: begin
                pmode         = PM_NORMAL;
                ev.event_kind = EV_OPT;
                ev.cmd_code   = pend_cmd;
                ev.opt_code   = b;
                has_event     = 1'b1;
            end
            default: begin
                if (b == B_IAC) begin
                    pmode    = PM_IAC;
                    pend_cmd = '0;
                end else if (sub_cnt < SUB_DEPTH) begin
                    // bytes past the buffer depth are dropped
                    sub_buf[sub_cnt] = b;
                    sub_cnt++;
                end
            end
        endcase
        if (has_event) begin
            ev.win_width  = win_w;
            ev.win_height = win_h;
            expected_events.push_back(ev);
        end
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Stimulus helpers
    function automatic logic [7:0] plain_byte();
        return 8'($urandom_range(0, 254));
    endfunction

    function automatic logic [7:0] any_cmd();
        case ($urandom_range(0, 3))
            0: return B_DO;
            1: return B_WILL;
            2: return B_DONT;
            default: return B_WONT;
        endcase
    endfunction

    task automatic push_sub_body(input int len);
        for (int i = 0; i < len; i++) rx_stream.push_back(plain_byte());
    endtask

    // One random sequence; most are well formed, some broken on purpose
    task automatic push_sequence();
        int          sel;
        int          len;
        logic [7:0]  b;
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) rx_stream.push_back(plain_byte());
        end else if (sel < 45) begin
            rx_stream.push_back(B_IAC);
            rx_stream.push_back(any_cmd());
            rx_stream.push_back(8'($urandom_range(0, 255)));
        end else if (sel < 55) begin
            // bare IAC with a non-command byte, IAC IAC included
            do b = 8'($urandom_range(0, 255));
            while (b == B_SB || b == B_SE || is_cmd(b));
            rx_stream.push_back(B_IAC);
            rx_stream.push_back(b);
        end else if (sel < 70) begin
            rx_stream.push_back(B_IAC);
            rx_stream.push_back(B_SB);
            rx_stream.push_back(OPT_NAWS);
            push_sub_body(4);
            rx_stream.push_back(B_IAC);
            rx_stream.push_back(B_SE);
        end else if (sel < 85) begin
            // generic subnegotiation, lengths past the buffer depth too
            len = $urandom_range(0, SUB_DEPTH + 8);
            rx_stream.push_back(B_IAC);
            rx_stream.push_back(B_SB);
            if (len > 0 && $urandom_range(0, 1)) begin
                rx_stream.push_back(OPT_NAWS);
                len--;
            end
            push_sub_body(len);
            rx_stream.push_back(B_IAC);
            rx_stream.push_back(B_SE);
        end else begin
            case ($urandom_range(0, 4))
                0: begin
                    // command sequence breaks into a subnegotiation
                    rx_stream.push_back(B_IAC);
                    rx_stream.push_back(B_SB);
                    push_sub_body($urandom_range(0, 6));
                    rx_stream.push_back(B_IAC);
                    rx_stream.push_back(any_cmd());
                    rx_stream.push_back(8'($urandom_range(0, 255)));
                end
                1: begin
                    // restarted subnegotiation
                    rx_stream.push_back(B_IAC);
                    rx_stream.push_back(B_SB);
                    push_sub_body($urandom_range(0, 6));
                    rx_stream.push_back(B_IAC);
                    rx_stream.push_back(B_SB);
                    if ($urandom_range(0, 1)) rx_stream.push_back(OPT_NAWS);
                    push_sub_body($urandom_range(0, 5));
                    rx_stream.push_back(B_IAC);
                    rx_stream.push_back(B_SE);
                end
                2: begin
                    // IAC plus a plain byte leaves the subnegotiation
                    rx_stream.push_back(B_IAC);
                    rx_stream.push_back(B_SB);
                    push_sub_body($urandom_range(0, 6));
                    rx_stream.push_back(B_IAC);
                    rx_stream.push_back($urandom_range(0, 1) ? B_IAC : plain_byte());
                end
                3: begin
                    rx_stream.push_back(B_IAC);
                    rx_stream.push_back(B_SE);
                end
                default: begin
                    len = $urandom_range(1, 4);
                    for (int i = 0; i < len; i++)
                        rx_stream.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    // Stimulus: directed bytes first, then random sequences
    initial begin
        int base;
        foreach (sub_buf[i]) sub_buf[i] = '0;
        rx_stream = '{8'h00,
                      B_IAC, B_DO, 8'h01,
                      B_IAC, B_WILL, OPT_NAWS,
                      B_IAC, B_DONT, 8'hFF,
                      B_IAC, B_WONT, 8'h00,
                      B_IAC, 8'hF1,
                      B_IAC, B_SE,
                      B_IAC, B_SB, OPT_NAWS, 8'hFF, 8'hFF, 8'hFF, 8'hFF, B_IAC, B_SE};
        base = rx_stream.size();
        while (rx_stream.size() < base + RAND_BYTES) push_sequence();
    end

    // Sender: bursts of random length separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_rx_byte(s_tdata);
                bytes_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || rx_stream.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= rx_stream.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Receiver: stall pattern cycles through ready, random, mostly stalled, mostly ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_tick = 0;
        end else begin
            stall_tick++;
            case ((stall_tick / 64) % 4)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Monitor: compare each result transaction with the oldest expected event
    always @(posedge aclk) begin
        tcp_result_t ev;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_events.size() == 0) begin
                $error("unexpected event: kind %0d tdata 0x%0h", m_tuser, m_tdata);
                errors++;
            end else begin
                ev = expected_events.pop_front();
                check_field("event_kind",   ev.event_kind,   m_tuser);
                check_field("data_byte",    ev.data_byte,    m_tdata[7:0]);
                check_field("cmd_code",     ev.cmd_code,     m_tdata[15:8]);
                check_field("opt_code",     ev.opt_code,     m_tdata[23:16]);
                check_field("sub_length",   ev.sub_length,   m_tdata[28:24]);
                check_field("size_updated", ev.size_updated, m_tdata[29]);
                check_field("win_width",    ev.win_width,    m_tdata[45:30]);
                check_field("win_height",   ev.win_height,   m_tdata[61:46]);
                case (ev.event_kind)
                    EV_DATA: n_data++;
                    EV_OPT:  n_opt++;
                    default: n_se++;
                endcase
                if (ev.size_updated) n_size++;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Reset, then wait for the stream to drain
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (rx_stream.size() != 0 || s_tvalid || expected_events.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (expected_events.size() != 0) begin
            $error("%0d expected events never arrived", expected_events.size());
            errors++;
        end
        $display("Sent %0d bytes; saw %0d data, %0d option and %0d subnegotiation-end events",
                 bytes_sent, n_data, n_opt, n_se);
        $display("Window size reports applied: %0d; mismatches: %0d", n_size, errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
